// File: hdl/audio_sector_slip_detector_top_defines.svh
// Assertion macros used by the slip detector sequencer (asd_seq).
`ifndef AUDIO_SECTOR_SLIP_DETECTOR_TOP_DEFINES_SVH
`define AUDIO_SECTOR_SLIP_DETECTOR_TOP_DEFINES_SVH

`ifndef SYNTH
`define ASD_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define ASD_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define ASD_ASSERT(name, prop, msg)
`define ASD_ASSERT_ALWAYS(name, prop, msg)
`endif

`endif

// File: hdl/asd_pkg.sv
`default_nettype none

package asd_pkg;

  localparam int SECTOR_BYTES_DEF = 2352;
  localparam int MAX_SHIFT_DEF    = 588;
  localparam int ANCHOR_BYTES_DEF = 64;

  typedef logic [31:0]        word_t;
  typedef logic signed [9:0]  shift_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SIL,
    ST_ANC,
    ST_FULL,
    ST_DONE
  } seq_state_e;

  typedef enum logic {
    CMP_REF,
    CMP_PAIR
  } cmp_mode_e;

  typedef struct packed {
    cmp_mode_e   mode;
    logic [3:0]  mask;
    logic [7:0]  ref_byte;
  } cmp_ctrl_t;

endpackage

`default_nettype wire

// File: hdl/audio_sector_slip_detector_top.sv
// Load: one word pair per cycle, stall low while loading.
// Search after the last pair: an anchor flatness scan over Awn words (Awn = anchor words,
// 16 by default), then per shift an anchor check ending at the first word that misses and,
// on a match, a full check of the overlap; one word pair read and compared per cycle.
// The result word is held until taken; input stalls from the last pair until then.
// Reset: asynchronous, active low; back to loading at index 0, sample stores are not cleared.
`default_nettype none

module audio_sector_slip_detector_top #(
  parameter int SECTOR_BYTES = asd_pkg::SECTOR_BYTES_DEF,
  parameter int MAX_SHIFT    = asd_pkg::MAX_SHIFT_DEF,
  parameter int ANCHOR_BYTES = asd_pkg::ANCHOR_BYTES_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  asd_pkg::word_t     first_word_i,
  input  asd_pkg::word_t     second_word_i,
  input  wire logic          last_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output logic               found_o,
  output asd_pkg::shift_t    shift_samples_o,
  output logic               silent_anchor_o
);

  localparam int AddrW = $clog2(SECTOR_BYTES / 4);

  logic               wr_en;
  logic [AddrW-1:0]   wr_addr;
  logic [AddrW-1:0]   rd_addr_f;
  logic [AddrW-1:0]   rd_addr_s;
  asd_pkg::word_t     rd_first;
  asd_pkg::word_t     rd_second;
  logic               match;
  asd_pkg::cmp_ctrl_t cmp_ctrl;

  asd_seq #(
    .SECTOR_BYTES (SECTOR_BYTES),
    .MAX_SHIFT    (MAX_SHIFT),
    .ANCHOR_BYTES (ANCHOR_BYTES)
  ) u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .last_i          (last_i),
    .in_stall_o      (in_stall_o),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .found_o         (found_o),
    .shift_samples_o (shift_samples_o),
    .silent_anchor_o (silent_anchor_o),
    .wr_en_o         (wr_en),
    .wr_addr_o       (wr_addr),
    .rd_addr_f_o     (rd_addr_f),
    .rd_addr_s_o     (rd_addr_s),
    .rd_first_i      (rd_first),
    .match_i         (match),
    .cmp_o           (cmp_ctrl)
  );

  asd_store #(
    .SECTOR_WORDS (SECTOR_BYTES / 4)
  ) u_store (
    .clk_i       (clk_i),
    .wr_en_i     (wr_en),
    .wr_addr_i   (wr_addr),
    .wr_first_i  (first_word_i),
    .wr_second_i (second_word_i),
    .rd_addr_f_i (rd_addr_f),
    .rd_addr_s_i (rd_addr_s),
    .rd_first_o  (rd_first),
    .rd_second_o (rd_second)
  );

  asd_cmp u_cmp (
    .first_i  (rd_first),
    .second_i (rd_second),
    .ctrl_i   (cmp_ctrl),
    .match_o  (match)
  );

endmodule

`default_nettype wire

// File: hdl/asd_store.sv
`default_nettype none

module asd_store #(
  parameter int SECTOR_WORDS = asd_pkg::SECTOR_BYTES_DEF / 4,
  localparam int AddrW = $clog2(SECTOR_WORDS)
) (
  input  wire logic              clk_i,
  input  wire logic              wr_en_i,
  input  wire logic [AddrW-1:0]  wr_addr_i,
  input  asd_pkg::word_t         wr_first_i,
  input  asd_pkg::word_t         wr_second_i,
  input  wire logic [AddrW-1:0]  rd_addr_f_i,
  input  wire logic [AddrW-1:0]  rd_addr_s_i,
  output asd_pkg::word_t         rd_first_o,
  output asd_pkg::word_t         rd_second_o
);

  asd_pkg::word_t first_mem  [SECTOR_WORDS];
  asd_pkg::word_t second_mem [SECTOR_WORDS];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      first_mem[wr_addr_i]  <= wr_first_i;
      second_mem[wr_addr_i] <= wr_second_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_first_o  <= first_mem[rd_addr_f_i];
    rd_second_o <= second_mem[rd_addr_s_i];
  end

endmodule

`default_nettype wire

// File: hdl/asd_cmp.sv
`default_nettype none

module asd_cmp (
  input  asd_pkg::word_t     first_i,
  input  asd_pkg::word_t     second_i,
  input  asd_pkg::cmp_ctrl_t ctrl_i,
  output logic               match_o
);

  logic [3:0] eq;

  always_comb begin
    for (int b = 0; b < 4; b++) begin
      unique case (ctrl_i.mode)
        asd_pkg::CMP_REF:  eq[b] = (first_i[8*b +: 8] == ctrl_i.ref_byte);
        asd_pkg::CMP_PAIR: eq[b] = (first_i[8*b +: 8] == second_i[8*b +: 8]);
        default:           eq[b] = 1'b0;
      endcase
    end
    match_o = &(eq | ~ctrl_i.mask);
  end

endmodule

`default_nettype wire

// File: hdl/asd_seq.sv
`default_nettype none

`include "audio_sector_slip_detector_top_defines.svh"

module asd_seq #(
  parameter int SECTOR_BYTES = asd_pkg::SECTOR_BYTES_DEF,
  parameter int MAX_SHIFT    = asd_pkg::MAX_SHIFT_DEF,
  parameter int ANCHOR_BYTES = asd_pkg::ANCHOR_BYTES_DEF,
  localparam int AddrW = $clog2(SECTOR_BYTES / 4)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic              last_i,
  output logic                   in_stall_o,
  input  wire logic              out_stall_i,
  output logic                   out_valid_o,
  output logic                   found_o,
  output asd_pkg::shift_t        shift_samples_o,
  output logic                   silent_anchor_o,
  output logic                   wr_en_o,
  output logic [AddrW-1:0]       wr_addr_o,
  output logic [AddrW-1:0]       rd_addr_f_o,
  output logic [AddrW-1:0]       rd_addr_s_o,
  input  asd_pkg::word_t         rd_first_i,
  input  wire logic              match_i,
  output asd_pkg::cmp_ctrl_t     cmp_o
);

  localparam int SW     = SECTOR_BYTES / 4;
  localparam int CW     = AddrW + 1;
  localparam int Centre = 2 * SW;
  localparam int Alen   = (ANCHOR_BYTES > 2 * SW) ? 2 * SW : ANCHOR_BYTES;
  localparam int CWord  = Centre / 4;
  localparam int Cb     = Centre % 4;
  localparam int Hb     = (Centre + Alen - 1) % 4;
  localparam int Awn    = (Centre + Alen - 1) / 4 - CWord + 1;
  localparam int DminI  = (MAX_SHIFT > SW / 2) ? -(SW / 2) : -MAX_SHIFT;
  localparam int DmaxI  = (MAX_SHIFT < (2 * SW - Alen) / 4) ? MAX_SHIFT : (2 * SW - Alen) / 4;

  localparam logic [CW-1:0]        SWC    = CW'(SW);
  localparam logic [CW-1:0]        CWordC = CW'(CWord);
  localparam logic [CW-1:0]        AwnC   = CW'(Awn);
  localparam logic [CW-1:0]        OneC   = CW'(1);
  localparam logic signed [CW-1:0] CWordS = CW'(CWord);
  localparam logic signed [CW-1:0] Dmin   = CW'(DminI);
  localparam logic signed [CW-1:0] Dmax   = CW'(DmaxI);
  localparam logic signed [CW-1:0] DOne   = CW'(1);
  localparam logic signed [CW-1:0] DNeg1  = CW'(-1);
  localparam logic [3:0]           FMask  = 4'(15 << Cb);
  localparam logic [3:0]           LMask  = 4'(15 >> (3 - Hb));

  asd_pkg::seq_state_e state_q, state_d;

  logic [CW-1:0]        load_idx_q, load_idx_d;
  logic [CW-1:0]        k_q, k_d;
  logic [CW-1:0]        kd_q, kd_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic [CW-1:0]        fbase_q, fbase_d;
  logic [CW-1:0]        sbase_q, sbase_d;
  logic                 pend_q, pend_d;
  logic signed [CW-1:0] d_q, d_d;
  logic [7:0]           ref_q, ref_d;
  logic                 found_q, found_d;
  logic                 silent_q, silent_d;
  asd_pkg::shift_t      shift_q, shift_d;

  logic                 in_scan;
  logic                 issue;
  logic                 last_elem;
  logic                 miss;
  logic                 hit_last;
  logic signed [CW-1:0] d_nxt;
  logic                 nxt_done;
  logic [CW-1:0]        dmag;
  logic [CW-1:0]        fsum;
  logic [CW-1:0]        ssum;

  assign in_scan   = (state_q == asd_pkg::ST_SIL) || (state_q == asd_pkg::ST_ANC)
                     || (state_q == asd_pkg::ST_FULL);
  assign issue     = (k_q < cnt_q);
  assign last_elem = (kd_q == cnt_q - OneC);
  assign miss      = pend_q & ~match_i;
  assign hit_last  = pend_q & match_i & last_elem;
  assign d_nxt     = (d_q == DNeg1) ? DOne : d_q + DOne;
  assign nxt_done  = (d_nxt > Dmax);
  assign dmag      = d_q[CW-1] ? $unsigned(-d_q) : $unsigned(d_q);
  assign fsum      = fbase_q + k_q;
  assign ssum      = sbase_q + k_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      asd_pkg::ST_LOAD: begin
        if (in_valid_i && last_i) state_d = asd_pkg::ST_SIL;
      end
      asd_pkg::ST_SIL: begin
        if (miss) state_d = asd_pkg::ST_ANC;
        else if (hit_last) state_d = asd_pkg::ST_DONE;
      end
      asd_pkg::ST_ANC: begin
        if (miss) state_d = nxt_done ? asd_pkg::ST_DONE : asd_pkg::ST_ANC;
        else if (hit_last) state_d = asd_pkg::ST_FULL;
      end
      asd_pkg::ST_FULL: begin
        if (miss) state_d = nxt_done ? asd_pkg::ST_DONE : asd_pkg::ST_ANC;
        else if (hit_last) state_d = asd_pkg::ST_DONE;
      end
      asd_pkg::ST_DONE: begin
        if (!out_stall_i) state_d = asd_pkg::ST_LOAD;
      end
      default: state_d = asd_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    in_stall_o      = (state_q != asd_pkg::ST_LOAD);
    out_valid_o     = (state_q == asd_pkg::ST_DONE);
    found_o         = found_q;
    shift_samples_o = shift_q;
    silent_anchor_o = silent_q;
    wr_en_o         = (state_q == asd_pkg::ST_LOAD) && in_valid_i && (load_idx_q < SWC);
    wr_addr_o       = load_idx_q[AddrW-1:0];
    rd_addr_f_o     = fsum[AddrW-1:0];
    rd_addr_s_o     = ssum[AddrW-1:0];
    cmp_o.mode      = (state_q == asd_pkg::ST_SIL) ? asd_pkg::CMP_REF : asd_pkg::CMP_PAIR;
    if (state_q == asd_pkg::ST_FULL) begin
      cmp_o.mask = 4'hF;
    end else begin
      cmp_o.mask = ((kd_q == '0) ? FMask : 4'hF) & (last_elem ? LMask : 4'hF);
    end
    cmp_o.ref_byte  = (kd_q == '0) ? rd_first_i[8*Cb +: 8] : ref_q;
  end

  always_comb begin
    load_idx_d = load_idx_q;
    k_d        = issue ? k_q + OneC : k_q;
    kd_d       = k_q;
    pend_d     = in_scan & issue;
    cnt_d      = cnt_q;
    fbase_d    = fbase_q;
    sbase_d    = sbase_q;
    d_d        = d_q;
    ref_d      = ref_q;
    found_d    = found_q;
    silent_d   = silent_q;
    shift_d    = shift_q;
    unique case (state_q)
      asd_pkg::ST_LOAD: begin
        if (in_valid_i) begin
          if (load_idx_q < SWC) load_idx_d = load_idx_q + OneC;
          if (last_i) begin
            load_idx_d = '0;
            k_d        = '0;
            pend_d     = 1'b0;
            fbase_d    = CWordC;
            sbase_d    = CWordC;
            cnt_d      = AwnC;
            found_d    = 1'b0;
            silent_d   = 1'b0;
            shift_d    = '0;
          end
        end
      end
      asd_pkg::ST_SIL: begin
        if (pend_q && kd_q == '0) ref_d = cmp_o.ref_byte;
        if (miss) begin
          d_d     = Dmin;
          fbase_d = CWordC;
          sbase_d = $unsigned(CWordS + Dmin);
          cnt_d   = AwnC;
          k_d     = '0;
          pend_d  = 1'b0;
        end else if (hit_last) begin
          silent_d = 1'b1;
        end
      end
      asd_pkg::ST_ANC: begin
        if (miss) begin
          d_d     = d_nxt;
          fbase_d = CWordC;
          sbase_d = $unsigned(CWordS + d_nxt);
          cnt_d   = AwnC;
          k_d     = '0;
          pend_d  = 1'b0;
        end else if (hit_last) begin
          fbase_d = d_q[CW-1] ? dmag : '0;
          sbase_d = d_q[CW-1] ? '0 : dmag;
          cnt_d   = SWC - dmag;
          k_d     = '0;
          pend_d  = 1'b0;
        end
      end
      asd_pkg::ST_FULL: begin
        if (miss) begin
          d_d     = d_nxt;
          fbase_d = CWordC;
          sbase_d = $unsigned(CWordS + d_nxt);
          cnt_d   = AwnC;
          k_d     = '0;
          pend_d  = 1'b0;
        end else if (hit_last) begin
          found_d = 1'b1;
          shift_d = asd_pkg::shift_t'(d_q);
        end
      end
      asd_pkg::ST_DONE: begin
        pend_d = 1'b0;
      end
      default: begin
        pend_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= asd_pkg::ST_LOAD;
      load_idx_q <= '0;
      pend_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      load_idx_q <= load_idx_d;
      pend_q     <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q      <= k_d;
    kd_q     <= kd_d;
    cnt_q    <= cnt_d;
    fbase_q  <= fbase_d;
    sbase_q  <= sbase_d;
    d_q      <= d_d;
    ref_q    <= ref_d;
    found_q  <= found_d;
    silent_q <= silent_d;
    shift_q  <= shift_d;
  end

  `ASD_ASSERT(a_found_not_silent, out_valid_o && found_o |-> !silent_anchor_o, "found with silent anchor")
  `ASD_ASSERT(a_miss_zero_shift, out_valid_o && !found_o |-> shift_samples_o == '0, "nonzero shift without match")
  `ASD_ASSERT_ALWAYS(a_idx_bound, load_idx_q <= SWC, "load index past sector")
  `ASD_ASSERT(a_pend_range, pend_q |-> kd_q < cnt_q, "compare beyond scan length")
  `ASD_ASSERT(a_shift_nonzero, (state_q == asd_pkg::ST_ANC || state_q == asd_pkg::ST_FULL) |-> d_q != '0, "zero shift searched")

endmodule

`default_nettype wire

// File: sim/tb_audio_sector_slip_detector_top.sv
`timescale 1ns / 100ps

module tb_audio_sector_slip_detector_top;
  import asd_pkg::*;

  localparam int WORDS = SECTOR_BYTES_DEF / 4;
  localparam int MID_W = WORDS / 2;
  localparam int ANC_W = (ANCHOR_BYTES_DEF / 4 > WORDS - MID_W) ? WORDS - MID_W
                                                                 : ANCHOR_BYTES_DEF / 4;
  localparam int MAX_D = MAX_SHIFT_DEF;

  typedef enum logic [1:0] {
    SEC_FRESH,
    SEC_KEEP,
    SEC_NOISE
  } sector_kind_e;

  typedef enum logic [1:0] {
    FLAT_NONE,
    FLAT_EXACT,
    FLAT_NEAR
  } flat_e;

  typedef struct packed {
    logic   found;
    shift_t shift;
    logic   silent;
  } verdict_t;

  typedef struct packed {
    sector_kind_e      kind;
    flat_e             flat;
    logic [9:0]        len;
    logic signed [9:0] shift;
    logic [3:0]        period;
    logic [7:0]        fill;
    logic              typed;
    verdict_t          want;
  } sector_row_t;

  localparam int PLAN_ROWS = 16;
  localparam sector_row_t SECTOR_PLAN [PLAN_ROWS] = '{
    '{SEC_FRESH, FLAT_NONE,  10'd588, -10'sd294, 4'd0, 8'h00, 1'b1, '{1'b1, -10'sd294, 1'b0}},
    '{SEC_FRESH, FLAT_NONE,  10'd588,  10'sd278, 4'd0, 8'h00, 1'b1, '{1'b1,  10'sd278, 1'b0}},
    '{SEC_FRESH, FLAT_NONE,  10'd588,  10'sd0,   4'd0, 8'h00, 1'b0, '{1'b0,  10'sd0,   1'b0}},
    '{SEC_FRESH, FLAT_NONE,  10'd588, -10'sd1,   4'd0, 8'h00, 1'b0, '{1'b0,  10'sd0,   1'b0}},
    '{SEC_FRESH, FLAT_NONE,  10'd588,  10'sd1,   4'd0, 8'h00, 1'b0, '{1'b0,  10'sd0,   1'b0}},
    '{SEC_FRESH, FLAT_NONE,  10'd600,  10'sd7,   4'd0, 8'h00, 1'b0, '{1'b0,  10'sd0,   1'b0}},
    '{SEC_KEEP,  FLAT_NONE,  10'd1,    10'sd7,   4'd0, 8'h00, 1'b0, '{1'b0,  10'sd0,   1'b0}},
    '{SEC_NOISE, FLAT_NONE,  10'd2,    10'sd0,   4'd0, 8'h00, 1'b0, '{1'b0,  10'sd0,   1'b0}},
    '{SEC_FRESH, FLAT_NONE,  10'd588,  10'sd279, 4'd0, 8'h00, 1'b1, '{1'b0,  10'sd0,   1'b0}},
    '{SEC_FRESH, FLAT_NONE,  10'd588, -10'sd295, 4'd0, 8'h00, 1'b1, '{1'b0,  10'sd0,   1'b0}},
    '{SEC_KEEP,  FLAT_EXACT, 10'd310,  10'sd0,   4'd0, 8'h00, 1'b1, '{1'b0,  10'sd0,   1'b1}},
    '{SEC_KEEP,  FLAT_EXACT, 10'd310,  10'sd0,   4'd0, 8'hFF, 1'b1, '{1'b0,  10'sd0,   1'b1}},
    '{SEC_KEEP,  FLAT_NEAR,  10'd310,  10'sd0,   4'd0, 8'hA5, 1'b0, '{1'b0,  10'sd0,   1'b0}},
    '{SEC_FRESH, FLAT_NONE,  10'd588,  10'sd0,   4'd3, 8'h00, 1'b0, '{1'b0,  10'sd0,   1'b0}},
    '{SEC_FRESH, FLAT_NONE,  10'd588, -10'sd150, 4'd0, 8'h00, 1'b0, '{1'b0,  10'sd0,   1'b0}},
    '{SEC_KEEP,  FLAT_NONE,  10'd40,  -10'sd150, 4'd0, 8'h00, 1'b0, '{1'b0,  10'sd0,   1'b0}}
  };

  logic   clk_i;
  logic   rst_ni;
  logic   in_valid_i;
  logic   in_stall_o;
  word_t  first_word_i;
  word_t  second_word_i;
  logic   last_i;
  logic   out_valid_o;
  logic   out_stall_i;
  logic   found_o;
  shift_t shift_samples_o;
  logic   silent_anchor_o;

  word_t    plan_first [WORDS];
  word_t    plan_second [WORDS];
  word_t    first_copy [WORDS];
  word_t    second_copy [WORDS];
  int       fill_pos = 0;
  verdict_t pending_verdicts [$];
  verdict_t typed_verdict = '0;
  logic     use_typed = 1'b0;
  logic     calm = 1'b0;
  logic     hold_go = 1'b0;
  int       errors = 0;
  int       items_sent = 0;
  int       sectors_sent = 0;
  int       results_seen = 0;
  int       slips_seen = 0;
  int       silent_seen = 0;

  audio_sector_slip_detector_top u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .first_word_i    (first_word_i),
    .second_word_i   (second_word_i),
    .last_i          (last_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .found_o         (found_o),
    .shift_samples_o (shift_samples_o),
    .silent_anchor_o (silent_anchor_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("mismatch on result %0d, %s: got %0d, expected %0d", results_seen, field, got,
             want);
    errors++;
  endtask

  function automatic verdict_t find_slip();
    verdict_t   v;
    logic [7:0] b0;
    logic       same;
    int         d;
    int         i;
    int         span;
    v = '0;
    b0 = first_copy[MID_W][7:0];
    v.silent = 1'b1;
    for (i = 0; i < ANC_W; i++)
      if (first_copy[MID_W + i] != {4{b0}}) v.silent = 1'b0;
    if (v.silent) return v;
    for (d = -MAX_D; d <= MAX_D && !v.found; d++) begin
      if (d != 0 && MID_W + d >= 0 && MID_W + d + ANC_W <= WORDS) begin
        same = 1'b1;
        for (i = 0; i < ANC_W && same; i++)
          if (first_copy[MID_W + i] != second_copy[MID_W + d + i]) same = 1'b0;
        span = WORDS - (d < 0 ? -d : d);
        for (i = 0; i < span && same; i++)
          if (first_copy[d < 0 ? i - d : i] != second_copy[d < 0 ? i : i + d]) same = 1'b0;
        if (same) begin
          v.found = 1'b1;
          v.shift = shift_t'(d);
        end
      end
    end
    return v;
  endfunction

  // for fresh and kept sectors the second read equals the first moved by d samples: second[j] = first[j - d]
  function automatic void compose_sector(input sector_kind_e kind, input int n, input int d,
                                         input int period, input flat_e flat,
                                         input logic [7:0] fill);
    int i;
    int k;
    for (i = 0; i < WORDS; i++) begin
      plan_first[i] = $urandom;
      plan_second[i] = $urandom;
    end
    if (kind == SEC_FRESH && period > 0)
      for (i = period; i < WORDS; i++) plan_first[i] = plan_first[i % period];
    if (kind == SEC_KEEP) begin
      if (d < 0) begin
        for (i = 0; i < n; i++) begin
          k = i - d;
          if (k < WORDS) plan_second[i] = (k < n) ? plan_first[k] : first_copy[k];
        end
      end else begin
        for (i = 0; i < n; i++) begin
          k = i + d;
          if (k < WORDS) plan_first[i] = (k < n) ? plan_second[k] : second_copy[k];
        end
      end
    end
    if (flat != FLAT_NONE) begin
      for (i = 0; i < ANC_W; i++) plan_first[MID_W + i] = {4{fill}};
      if (flat == FLAT_NEAR) plan_first[MID_W + ANC_W - 1][31:24] = ~fill;
    end
    if (kind == SEC_FRESH)
      for (i = 0; i < WORDS; i++) begin
        k = i - d;
        if (k >= 0 && k < WORDS) plan_second[i] = plan_first[k];
      end
  endfunction

  task automatic send_word(input word_t fw, input word_t sw, input logic fin);
    logic taken;
    if (!calm)
      while ($urandom_range(99) < 34) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    in_valid_i <= 1'b1;
    first_word_i <= fw;
    second_word_i <= sw;
    last_i <= fin;
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
    items_sent++;
    if (fill_pos < WORDS) begin
      first_copy[fill_pos] = fw;
      second_copy[fill_pos] = sw;
      fill_pos++;
    end
    if (fin) begin
      fill_pos = 0;
      pending_verdicts.push_back(use_typed ? typed_verdict : find_slip());
      sectors_sent++;
    end
  endtask

  task automatic drive_sector(input int n);
    int i;
    for (i = 0; i < n; i++)
      if (i < WORDS) send_word(plan_first[i], plan_second[i], i == n - 1);
      else send_word($urandom, $urandom, i == n - 1);
  endtask

  initial begin
    int       hold_left;
    logic     hold_used;
    out_stall_i = 1'b0;
    hold_left = 0;
    hold_used = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_go && !hold_used) begin
        hold_used = 1'b1;
        hold_left = 5000;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !calm && ($urandom_range(99) < 34);
      end
    end
  end

  initial begin
    verdict_t want;
    forever begin
      @(negedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        results_seen++;
        if (pending_verdicts.size() == 0) begin
          report_mismatch("result with no sector pending", 1, 0);
        end else begin
          want = pending_verdicts.pop_front();
          if (found_o !== want.found) report_mismatch("found", found_o, want.found);
          if (shift_samples_o !== want.shift)
            report_mismatch("shift_samples", shift_samples_o, want.shift);
          if (silent_anchor_o !== want.silent)
            report_mismatch("silent_anchor", silent_anchor_o, want.silent);
          if (want.found) slips_seen++;
          if (want.silent) silent_seen++;
        end
      end
    end
  end

  initial begin
    int   r;
    int   n;
    int   pick;
    int   cur_d;
    int   base_items;
    int   base_sectors;
    int   flip_word;
    int   flip_bit;
    logic need_fresh;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    first_word_i = '0;
    second_word_i = '0;
    last_i = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (r = 0; r < PLAN_ROWS; r++) begin
      compose_sector(SECTOR_PLAN[r].kind, SECTOR_PLAN[r].len, SECTOR_PLAN[r].shift,
                     SECTOR_PLAN[r].period, SECTOR_PLAN[r].flat, SECTOR_PLAN[r].fill);
      use_typed = SECTOR_PLAN[r].typed;
      typed_verdict = SECTOR_PLAN[r].want;
      drive_sector(SECTOR_PLAN[r].len);
    end
    use_typed = 1'b0;

    // drain before random traffic
    in_valid_i <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);

    base_items = items_sent;
    base_sectors = sectors_sent;
    cur_d = -150;
    need_fresh = 1'b0;
    hold_go = 1'b1;
    while (items_sent - base_items < 1900 || sectors_sent - base_sectors < 40) begin
      calm = (sectors_sent - base_sectors >= 8) && (sectors_sent - base_sectors < 14);
      pick = $urandom_range(99);
      if (need_fresh || pick < 5) begin
        cur_d = int'($urandom_range(600)) - 300;
        n = ($urandom_range(3) == 0) ? WORDS + 1 + int'($urandom_range(15)) : WORDS;
        compose_sector(SEC_FRESH, n, cur_d, 0, FLAT_NONE, 8'h00);
        need_fresh = 1'b0;
      end else if (pick < 8) begin
        n = MID_W + ANC_W + int'($urandom_range(10));
        compose_sector(SEC_KEEP, n, cur_d, 0, $urandom_range(1) ? FLAT_EXACT : FLAT_NEAR,
                       8'($urandom));
        need_fresh = 1'b1;
      end else if (pick < 16) begin
        n = $urandom_range(40, 1);
        compose_sector(SEC_NOISE, n, 0, 0, FLAT_NONE, 8'h00);
      end else begin
        n = $urandom_range(40, 1);
        compose_sector(SEC_KEEP, n, cur_d, 0, FLAT_NONE, 8'h00);
        if ($urandom_range(7) == 0) begin
          flip_word = $urandom_range(n - 1);
          flip_bit = $urandom_range(31);
          plan_second[flip_word][flip_bit] = ~plan_second[flip_word][flip_bit];
        end
      end
      drive_sector(n);
    end
    calm = 1'b0;

    in_valid_i <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("%0d sectors from %0d word pairs: %0d slips found, %0d silent anchors",
             sectors_sent, items_sent, slips_seen, silent_seen);
    $display("covered: extreme and out-of-window shifts, identical and periodic reads, short and long sectors");
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
